/* hw/rtl/pacl_pkg.sv */
// Shared types and constants for the packet ACL filter.
// Used by the front, queue, back and top-level modules; no dependencies.
package pacl_pkg;

    typedef enum logic [2:0] {
        FN_CLASSIFY   = 3'd0,
        FN_ADD_PROTO  = 3'd1,
        FN_DEL_PROTO  = 3'd2,
        FN_ADD_RANGE  = 3'd3,
        FN_DEL_RANGE  = 3'd4,
        FN_ADD_SITE   = 3'd5,
        FN_DEL_SITE   = 3'd6,
        FN_NONE       = 3'd7
    } t_func;

    localparam logic [2:0] VD_ALLOWED = 3'd0;
    localparam logic [2:0] VD_PASSED  = 3'd1;
    localparam logic [2:0] VD_PROTO   = 3'd2;
    localparam logic [2:0] VD_RANGE   = 3'd3;
    localparam logic [2:0] VD_SITE    = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef struct packed {
        t_func       func;
        logic        is_l4;
        logic [7:0]  proto_key;
        logic [31:0] addr_key;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic [31:0] site_addr;
    } t_cmd;

endpackage

/* hw/rtl/pacl_front.sv */
// Front stage: takes requests, decodes them into commands for the queue.
// Depends on pacl_pkg.
module pacl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [2:0]     i_func,
    input  logic [7:0]     i_packet_protocol,
    input  logic [31:0]    i_packet_dest,
    input  logic [7:0]     i_rule_protocol,
    input  logic [31:0]    i_range_low,
    input  logic [31:0]    i_range_high,
    input  logic [31:0]    i_site_addr,
    output logic           o_push,
    output pacl_pkg::t_cmd o_cmd,
    input  logic           i_q_full
);

    logic           r_vld;
    pacl_pkg::t_cmd r_cmd;
    pacl_pkg::t_cmd n_cmd;

    always_comb begin
        n_cmd.func       = pacl_pkg::t_func'(i_func);
        n_cmd.is_l4      = (i_packet_protocol == pacl_pkg::PROTO_TCP) ||
                           (i_packet_protocol == pacl_pkg::PROTO_UDP);
        n_cmd.range_low  = i_range_low;
        n_cmd.range_high = i_range_high;
        n_cmd.site_addr  = i_site_addr;
        if (n_cmd.func == pacl_pkg::FN_CLASSIFY) begin
            n_cmd.proto_key = i_packet_protocol;
            n_cmd.addr_key  = i_packet_dest;
        end else begin
            n_cmd.proto_key = i_rule_protocol;
            n_cmd.addr_key  = i_site_addr;
        end
    end

    assign o_stall = r_vld && i_q_full;
    assign o_push  = r_vld && !i_q_full;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
        if (i_valid && !o_stall) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* hw/rtl/pacl_queue.sv */
// Two-entry command queue between the front and back stages.
// Depends on pacl_pkg.
module pacl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pacl_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output pacl_pkg::t_cmd o_cmd
);

    pacl_pkg::t_cmd r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/pacl_back.sv */
// Back stage: rule tables held in compare cells, table edits and verdicts.
// Depends on pacl_pkg.
module pacl_back #(
    parameter int PROTO_SLOTS = 16,
    parameter int RANGE_SLOTS = 16,
    parameter int SITE_SLOTS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  pacl_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [2:0]     o_verdict,
    output logic [1:0]     o_op_status
);

    localparam int PW = (PROTO_SLOTS > 1) ? $clog2(PROTO_SLOTS) : 1;
    localparam int RW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int SW = (SITE_SLOTS > 1) ? $clog2(SITE_SLOTS) : 1;

    logic [PROTO_SLOTS-1:0] r_pv;
    logic [7:0]             r_pe [PROTO_SLOTS];
    logic [RANGE_SLOTS-1:0] r_rv;
    logic [31:0]            r_rs [RANGE_SLOTS];
    logic [31:0]            r_re [RANGE_SLOTS];
    logic [SITE_SLOTS-1:0]  r_sv;
    logic [31:0]            r_se [SITE_SLOTS];

    logic                   r_ovld;
    logic [2:0]             r_verdict;
    logic [1:0]             r_status;
    logic [2:0]             n_verdict;
    logic [1:0]             n_status;

    logic [PROTO_SLOTS-1:0] p_hit;
    logic [RANGE_SLOTS-1:0] rg_hit;
    logic [RANGE_SLOTS-1:0] rg_in;
    logic [SITE_SLOTS-1:0]  s_hit;
    logic [PW-1:0]          p_hit_idx;
    logic [PW-1:0]          p_free_idx;
    logic [RW-1:0]          rg_hit_idx;
    logic [RW-1:0]          rg_free_idx;
    logic [SW-1:0]          s_hit_idx;
    logic [SW-1:0]          s_free_idx;
    logic                   p_wr;
    logic                   p_clr;
    logic                   rg_wr_new;
    logic                   rg_wr_end;
    logic                   rg_clr;
    logic                   s_wr;
    logic                   s_clr;

    always_comb begin
        p_hit_idx  = '0;
        p_free_idx = '0;
        for (int i = PROTO_SLOTS - 1; i >= 0; i--) begin
            p_hit[i] = r_pv[i] && (r_pe[i] == i_cmd.proto_key);
            if (p_hit[i]) begin
                p_hit_idx = PW'(i);
            end
            if (!r_pv[i]) begin
                p_free_idx = PW'(i);
            end
        end
        rg_hit_idx  = '0;
        rg_free_idx = '0;
        for (int i = RANGE_SLOTS - 1; i >= 0; i--) begin
            rg_hit[i] = r_rv[i] && (r_rs[i] == i_cmd.range_low);
            rg_in[i]  = r_rv[i] && (i_cmd.addr_key >= r_rs[i]) &&
                        (i_cmd.addr_key <= r_re[i]);
            if (rg_hit[i]) begin
                rg_hit_idx = RW'(i);
            end
            if (!r_rv[i]) begin
                rg_free_idx = RW'(i);
            end
        end
        s_hit_idx  = '0;
        s_free_idx = '0;
        for (int i = SITE_SLOTS - 1; i >= 0; i--) begin
            s_hit[i] = r_sv[i] && (r_se[i] == i_cmd.addr_key);
            if (s_hit[i]) begin
                s_hit_idx = SW'(i);
            end
            if (!r_sv[i]) begin
                s_free_idx = SW'(i);
            end
        end
    end

    always_comb begin
        n_verdict = pacl_pkg::VD_ALLOWED;
        n_status  = pacl_pkg::ST_DONE;
        p_wr      = 1'b0;
        p_clr     = 1'b0;
        rg_wr_new = 1'b0;
        rg_wr_end = 1'b0;
        rg_clr    = 1'b0;
        s_wr      = 1'b0;
        s_clr     = 1'b0;
        case (i_cmd.func)
            pacl_pkg::FN_CLASSIFY: begin
                if (|p_hit) begin
                    n_verdict = pacl_pkg::VD_PROTO;
                end else if (|rg_in) begin
                    n_verdict = pacl_pkg::VD_RANGE;
                end else if (i_cmd.is_l4) begin
                    n_verdict = (|s_hit) ? pacl_pkg::VD_SITE : pacl_pkg::VD_ALLOWED;
                end else begin
                    n_verdict = pacl_pkg::VD_PASSED;
                end
            end
            pacl_pkg::FN_ADD_PROTO: begin
                if (|p_hit) begin
                    n_status = pacl_pkg::ST_DUP;
                end else if (&r_pv) begin
                    n_status = pacl_pkg::ST_FULL;
                end else begin
                    p_wr = 1'b1;
                end
            end
            pacl_pkg::FN_DEL_PROTO: begin
                if (|p_hit) begin
                    p_clr = 1'b1;
                end else begin
                    n_status = pacl_pkg::ST_MISSING;
                end
            end
            pacl_pkg::FN_ADD_RANGE: begin
                if (|rg_hit) begin
                    rg_wr_end = 1'b1;
                end else if (&r_rv) begin
                    n_status = pacl_pkg::ST_FULL;
                end else begin
                    rg_wr_new = 1'b1;
                end
            end
            pacl_pkg::FN_DEL_RANGE: begin
                if ((|rg_hit) && (r_re[rg_hit_idx] == i_cmd.range_high)) begin
                    rg_clr = 1'b1;
                end else begin
                    n_status = pacl_pkg::ST_MISSING;
                end
            end
            pacl_pkg::FN_ADD_SITE: begin
                if (|s_hit) begin
                    n_status = pacl_pkg::ST_DUP;
                end else if (&r_sv) begin
                    n_status = pacl_pkg::ST_FULL;
                end else begin
                    s_wr = 1'b1;
                end
            end
            pacl_pkg::FN_DEL_SITE: begin
                if (|s_hit) begin
                    s_clr = 1'b1;
                end else begin
                    n_status = pacl_pkg::ST_MISSING;
                end
            end
            default: begin
                n_verdict = pacl_pkg::VD_ALLOWED;
            end
        endcase
    end

    assign o_pop       = i_q_valid && (!r_ovld || !i_stall);
    assign o_valid     = r_ovld;
    assign o_verdict   = r_verdict;
    assign o_op_status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_pv   <= '0;
            r_rv   <= '0;
            r_sv   <= '0;
        end else begin
            if (o_pop) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
            if (o_pop && p_wr) begin
                r_pv[p_free_idx] <= 1'b1;
            end
            if (o_pop && p_clr) begin
                r_pv[p_hit_idx] <= 1'b0;
            end
            if (o_pop && rg_wr_new) begin
                r_rv[rg_free_idx] <= 1'b1;
            end
            if (o_pop && rg_clr) begin
                r_rv[rg_hit_idx] <= 1'b0;
            end
            if (o_pop && s_wr) begin
                r_sv[s_free_idx] <= 1'b1;
            end
            if (o_pop && s_clr) begin
                r_sv[s_hit_idx] <= 1'b0;
            end
        end
        if (o_pop) begin
            r_verdict <= n_verdict;
            r_status  <= n_status;
        end
        if (o_pop && p_wr) begin
            r_pe[p_free_idx] <= i_cmd.proto_key;
        end
        if (o_pop && rg_wr_new) begin
            r_rs[rg_free_idx] <= i_cmd.range_low;
            r_re[rg_free_idx] <= i_cmd.range_high;
        end
        if (o_pop && rg_wr_end) begin
            r_re[rg_hit_idx] <= i_cmd.range_high;
        end
        if (o_pop && s_wr) begin
            r_se[s_free_idx] <= i_cmd.addr_key;
        end
    end

endmodule

/* hw/rtl/packet_acl_filter.sv */
// Top level of the packet ACL filter: front decoder, command queue, back stage.
// Depends on pacl_pkg, pacl_front, pacl_queue and pacl_back.
//
// Each request either edits one rule table or classifies an IPv4 header and
// yields exactly one result. The back stage checks every rule of all tables in
// parallel compare cells, so it retires one request per cycle while its output is
// not stalled. After a request is accepted it passes the front register and one
// queue entry before it is loaded into the output register.
// A two-entry queue lets the front keep accepting while the output is stalled.
module packet_acl_filter #(
    parameter int PROTO_SLOTS = 16,
    parameter int RANGE_SLOTS = 16,
    parameter int SITE_SLOTS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_packet_protocol,
    input  logic [31:0] i_packet_dest,
    input  logic [7:0]  i_rule_protocol,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    input  logic [31:0] i_site_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_verdict,
    output logic [1:0]  o_op_status
);

    logic           w_push;
    logic           w_q_full;
    logic           w_q_vld;
    logic           w_pop;
    pacl_pkg::t_cmd w_f_cmd;
    pacl_pkg::t_cmd w_q_cmd;

    pacl_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_packet_protocol (i_packet_protocol),
        .i_packet_dest     (i_packet_dest),
        .i_rule_protocol   (i_rule_protocol),
        .i_range_low       (i_range_low),
        .i_range_high      (i_range_high),
        .i_site_addr       (i_site_addr),
        .o_push            (w_push),
        .o_cmd             (w_f_cmd),
        .i_q_full          (w_q_full)
    );

    pacl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_f_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_vld),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd)
    );

    pacl_back #(
        .PROTO_SLOTS (PROTO_SLOTS),
        .RANGE_SLOTS (RANGE_SLOTS),
        .SITE_SLOTS  (SITE_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_vld),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_verdict   (o_verdict),
        .o_op_status (o_op_status)
    );

`ifndef SYNTHESIS
    a_verdict_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_op_status == pacl_pkg::ST_DONE || o_verdict == pacl_pkg::VD_ALLOWED))
        else $error("verdict and status both set");
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_q_full)
        else $error("input stalled with queue space free");
    a_no_pop_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !w_pop)
        else $error("queue popped while output is held");
`endif

endmodule
